/* design/mf2d_pkg.sv */
`default_nettype none
package mf2d_pkg;
   // request modes
   typedef enum logic {
      MODE_WRITE = 1'b0,
      MODE_QUERY = 1'b1
   } mode_type;

   // configuration register indexes
   localparam logic [1:0] CSR_LINE_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_NUM_LINES   = 2'd1;
   localparam logic [1:0] CSR_HALF_WINDOW = 2'd2;

   // field widths fixed by the interface
   localparam int CfgBits    = 9;
   localparam int HalfBits   = 2;
   localparam int CoordBits  = 8;
   localparam int PortSample = 16;
endpackage
`default_nettype wire

/* design/median_filter_2d_mirror.sv */
`default_nettype none
// Median filter over a stored frame with mirrored edges.
// A pixel write is stored on acceptance; busy stays low and the next transaction may follow at once.
// A query steps through the read, drain and median states before the result strobe, with busy high,
// paced by the frame memory's single read port: one window pixel is fetched per cycle.
// Results are strobed for one cycle; the receiver cannot stall them.
// Reset returns the sequencer to idle and the registers to 256, 256, 1; the frame memory is not cleared.
module median_filter_2d_mirror #(
   parameter int MAX_WIDTH   = 256,
   parameter int MAX_HEIGHT  = 256,
   parameter int MAX_HALF    = 3,
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire logic                               req_mode,
   input  wire logic [mf2d_pkg::CoordBits-1:0]     req_row,
   input  wire logic [mf2d_pkg::CoordBits-1:0]     req_col,
   input  wire logic [mf2d_pkg::PortSample-1:0]    req_sample,
   output logic                                    rsp_valid,
   output logic [mf2d_pkg::PortSample-1:0]         rsp_median_value,
   output logic [mf2d_pkg::CoordBits-1:0]          rsp_out_row,
   output logic [mf2d_pkg::CoordBits-1:0]          rsp_out_col,
   input  wire logic                               csr_we,
   input  wire logic [1:0]                         csr_index,
   input  wire logic [mf2d_pkg::CfgBits-1:0]       csr_wdata
);
   localparam int MaxDim  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
   localparam int DimLog  = ($clog2(MaxDim) > mf2d_pkg::CfgBits) ? $clog2(MaxDim)
                                                                 : mf2d_pkg::CfgBits;
   localparam int SW      = DimLog + 3;
   localparam int Depth   = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW      = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int Side    = 2 * MAX_HALF + 1;
   localparam int Cells   = Side * Side;
   localparam int CntW    = $clog2(Cells + 1);
   localparam int CellIxW = $clog2(Cells);
   localparam int OW      = $clog2(MAX_HALF + 1) + 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_DRAIN,
      ST_MEDIAN
   } state_type;

   // configuration registers
   logic [mf2d_pkg::CfgBits-1:0]  line_width_ff, num_lines_ff;
   logic [mf2d_pkg::HalfBits-1:0] half_window_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff  <= mf2d_pkg::CfgBits'(256);
         num_lines_ff   <= mf2d_pkg::CfgBits'(256);
         half_window_ff <= mf2d_pkg::HalfBits'(1);
      end else if (csr_we) begin
         unique case (csr_index)
            mf2d_pkg::CSR_LINE_WIDTH:  line_width_ff  <= csr_wdata;
            mf2d_pkg::CSR_NUM_LINES:   num_lines_ff   <= csr_wdata;
            mf2d_pkg::CSR_HALF_WINDOW: half_window_ff <= csr_wdata[mf2d_pkg::HalfBits-1:0];
            default: ;
         endcase
      end
   end

   // query geometry, worked out on acceptance
   logic signed [SW-1:0] w_c, hgt_c, h_c, r_c, c_c;

   always_comb begin
      w_c = SW'(signed'({1'b0, line_width_ff}));
      if (w_c < SW'(1)) w_c = SW'(1);
      if (w_c > SW'(MAX_WIDTH)) w_c = SW'(MAX_WIDTH);
      hgt_c = SW'(signed'({1'b0, num_lines_ff}));
      if (hgt_c < SW'(1)) hgt_c = SW'(1);
      if (hgt_c > SW'(MAX_HEIGHT)) hgt_c = SW'(MAX_HEIGHT);
      h_c = SW'(signed'({1'b0, half_window_ff}));
      if (h_c > SW'(MAX_HALF)) h_c = SW'(MAX_HALF);
      if (h_c > w_c - SW'(1)) h_c = w_c - SW'(1);
      if (h_c > hgt_c - SW'(1)) h_c = hgt_c - SW'(1);
      r_c = SW'(signed'({1'b0, req_row}));
      if (r_c >= hgt_c) r_c = hgt_c - SW'(1);
      c_c = SW'(signed'({1'b0, req_col}));
      if (c_c >= w_c) c_c = w_c - SW'(1);
   end

   state_type                     state_ff;
   logic signed [SW-1:0]          w_ff, hgt_ff, r_ff, c_ff;
   logic signed [OW-1:0]          h_ff, dr_ff, dc_ff;
   logic [mf2d_pkg::CoordBits-1:0] row_ff, col_ff;
   logic                          rd_valid_ff;
   logic [CntW-1:0]               cnt_ff;
   logic [SAMPLE_BITS-1:0]        cell_ff [Cells];
   logic [SAMPLE_BITS-1:0]        rd_data_ff;
   logic [SAMPLE_BITS-1:0]        mem [Depth];

   logic accept, last_tap;
   assign accept   = start && (state_ff == ST_IDLE);
   assign busy     = (state_ff != ST_IDLE);
   assign last_tap = (dr_ff == h_ff) && (dc_ff == h_ff);

   // mirrored window address
   logic signed [SW-1:0] rr_c, cc_c;
   logic [AW-1:0]        rd_addr_c;

   always_comb begin
      rr_c = r_ff + SW'(dr_ff);
      if (rr_c < SW'(0)) rr_c = -rr_c;
      else if (rr_c >= hgt_ff) rr_c = SW'(2) * (hgt_ff - SW'(1)) - rr_c;
      cc_c = c_ff + SW'(dc_ff);
      if (cc_c < SW'(0)) cc_c = -cc_c;
      else if (cc_c >= w_ff) cc_c = SW'(2) * (w_ff - SW'(1)) - cc_c;
      rd_addr_c = AW'(rr_c) * AW'(MAX_WIDTH) + AW'(cc_c);
   end

   // frame memory: one write port, one registered read port
   logic          wr_en_c;
   logic [AW-1:0] wr_addr_c;
   assign wr_en_c = accept && (req_mode == mf2d_pkg::MODE_WRITE)
                    && (32'(req_col) < MAX_WIDTH) && (32'(req_row) < MAX_HEIGHT);
   assign wr_addr_c = AW'(req_row) * AW'(MAX_WIDTH) + AW'(req_col);

   always_ff @(posedge clock) begin
      if (wr_en_c) begin
         mem[wr_addr_c] <= SAMPLE_BITS'(req_sample);
      end
      if (state_ff == ST_READ) begin
         rd_data_ff <= mem[rd_addr_c];
      end
   end

   // insertion sorter: a row of cells kept in ascending order
   logic [SAMPLE_BITS-1:0] cell_in [Cells];
   logic                   larger [Cells];

   always_comb begin
      for (int i = 0; i < Cells; i++) begin
         larger[i] = (CntW'(i) >= cnt_ff) || (rd_data_ff < cell_ff[i]);
      end
      for (int i = 0; i < Cells; i++) begin
         cell_in[i] = cell_ff[i];
         if (larger[i]) begin
            if (i > 0 && larger[(i > 0) ? i - 1 : 0]) cell_in[i] = cell_ff[(i > 0) ? i - 1 : 0];
            else cell_in[i] = rd_data_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_valid_ff) begin
         for (int i = 0; i < Cells; i++) begin
            cell_ff[i] <= cell_in[i];
         end
      end
   end

   logic [SAMPLE_BITS-1:0] median_c;
   assign median_c = cell_ff[CellIxW'(cnt_ff >> 1)];

   // sequencer and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         rd_valid_ff <= 1'b0;
         cnt_ff      <= '0;
         rsp_valid   <= 1'b0;
      end else begin
         rsp_valid   <= 1'b0;
         rd_valid_ff <= (state_ff == ST_READ);
         if (rd_valid_ff) cnt_ff <= cnt_ff + CntW'(1);
         unique case (state_ff)
            ST_IDLE: begin
               if (accept && (req_mode == mf2d_pkg::MODE_QUERY)) begin
                  w_ff     <= w_c;
                  hgt_ff   <= hgt_c;
                  r_ff     <= r_c;
                  c_ff     <= c_c;
                  h_ff     <= OW'(h_c);
                  dr_ff    <= -OW'(h_c);
                  dc_ff    <= -OW'(h_c);
                  row_ff   <= req_row;
                  col_ff   <= req_col;
                  cnt_ff   <= '0;
                  state_ff <= ST_READ;
               end
            end
            ST_READ: begin
               if (last_tap) begin
                  state_ff <= ST_DRAIN;
               end else if (dc_ff == h_ff) begin
                  dc_ff <= -h_ff;
                  dr_ff <= dr_ff + OW'(1);
               end else begin
                  dc_ff <= dc_ff + OW'(1);
               end
            end
            ST_DRAIN: state_ff <= ST_MEDIAN;
            ST_MEDIAN: begin
               rsp_median_value <= mf2d_pkg::PortSample'(median_c);
               rsp_out_row      <= row_ff;
               rsp_out_col      <= col_ff;
               rsp_valid        <= 1'b1;
               state_ff         <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // checks
   a_rsp_after_median: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_MEDIAN)) else $error("result without median step");
   a_rd_after_read: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> $past(state_ff == ST_READ)) else $error("stray read data");
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CntW'(Cells)) else $error("window count overflow");
endmodule
`default_nettype wire

/* test/tb.sv */
`default_nettype none
module tb;

   // stimulus and block ports
   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            start = 1'b0;
   logic                            busy;
   logic                            req_mode = 1'b0;
   logic [mf2d_pkg::CoordBits-1:0]  req_row = '0;
   logic [mf2d_pkg::CoordBits-1:0]  req_col = '0;
   logic [mf2d_pkg::PortSample-1:0] req_sample = '0;
   logic                            rsp_valid;
   logic [mf2d_pkg::PortSample-1:0] rsp_median_value;
   logic [mf2d_pkg::CoordBits-1:0]  rsp_out_row;
   logic [mf2d_pkg::CoordBits-1:0]  rsp_out_col;
   logic                            csr_we = 1'b0;
   logic [1:0]                      csr_index = '0;
   logic [mf2d_pkg::CfgBits-1:0]    csr_wdata = '0;

   typedef struct {
      logic [mf2d_pkg::PortSample-1:0] med;
      logic [mf2d_pkg::CoordBits-1:0]  row;
      logic [mf2d_pkg::CoordBits-1:0]  col;
   } filtered_pixel_type;

   filtered_pixel_type median_queue[$];

   // predictor state: frame store, written flags and raw register values
   logic [mf2d_pkg::PortSample-1:0] frame_copy [0:65535];
   bit                              frame_written [0:65535];
   logic [mf2d_pkg::CfgBits-1:0]    width_reg = 9'd256;
   logic [mf2d_pkg::CfgBits-1:0]    lines_reg = 9'd256;
   logic [mf2d_pkg::HalfBits-1:0]   half_reg  = 2'd1;

   int mismatches = 0;
   int sender_idle_pct = 25;

   median_filter_2d_mirror u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_mode(req_mode), .req_row(req_row), .req_col(req_col), .req_sample(req_sample),
      .rsp_valid(rsp_valid), .rsp_median_value(rsp_median_value),
      .rsp_out_row(rsp_out_row), .rsp_out_col(rsp_out_col),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int eff_dim(logic [mf2d_pkg::CfgBits-1:0] v);
      if (v == 0) return 1;
      if (v > 256) return 256;
      return int'(v);
   endfunction

   function automatic int mirror_idx(int i, int n);
      if (i < 0) return -i;
      if (i >= n) return 2 * (n - 1) - i;
      return i;
   endfunction

   // median of the mirrored window; returns 0 if any pixel read is unwritten
   function automatic bit window_median(logic [7:0] row, logic [7:0] col,
                                        output logic [mf2d_pkg::PortSample-1:0] med);
      logic [mf2d_pkg::PortSample-1:0] vals [0:48];
      logic [mf2d_pkg::PortSample-1:0] v;
      int w, hg, h, r, c, n, rr, cc, j;
      w = eff_dim(width_reg);
      hg = eff_dim(lines_reg);
      h = int'(half_reg);
      if (h > w - 1) h = w - 1;
      if (h > hg - 1) h = hg - 1;
      r = (row < hg) ? int'(row) : hg - 1;
      c = (col < w) ? int'(col) : w - 1;
      n = 0;
      med = '0;
      for (int dr = -h; dr <= h; dr++) begin
         rr = mirror_idx(r + dr, hg);
         for (int dc = -h; dc <= h; dc++) begin
            cc = mirror_idx(c + dc, w);
            if (!frame_written[rr * 256 + cc]) return 1'b0;
            vals[n] = frame_copy[rr * 256 + cc];
            n++;
         end
      end
      // insertion sort, then take the middle
      for (int i = 1; i < n; i++) begin
         v = vals[i];
         j = i;
         while (j > 0 && vals[j - 1] > v) begin
            vals[j] = vals[j - 1];
            j--;
         end
         vals[j] = v;
      end
      med = vals[n >> 1];
      return 1'b1;
   endfunction

   // one transaction on the request side, followed by a random gap
   task automatic send_op(mf2d_pkg::mode_type m, logic [7:0] r, logic [7:0] c,
                          logic [15:0] s);
      filtered_pixel_type e;
      int gap;
      @(negedge clock);
      start <= 1'b1;
      req_mode <= m;
      req_row <= r;
      req_col <= c;
      req_sample <= s;
      do @(posedge clock); while (busy);
      if (m == mf2d_pkg::MODE_WRITE) begin
         frame_copy[int'(r) * 256 + int'(c)] = s;
         frame_written[int'(r) * 256 + int'(c)] = 1'b1;
      end else begin
         void'(window_median(r, c, e.med));
         e.row = r;
         e.col = c;
         median_queue.push_back(e);
      end
      // idle cycle by cycle with the given chance
      gap = 0;
      while (($urandom_range(99) < sender_idle_pct) && (gap < 20)) gap++;
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // query only where the window is fully written; otherwise write that pixel
   task automatic try_query(logic [7:0] r, logic [7:0] c);
      logic [mf2d_pkg::PortSample-1:0] med;
      if (window_median(r, c, med)) send_op(mf2d_pkg::MODE_QUERY, r, c, 16'($urandom));
      else send_op(mf2d_pkg::MODE_WRITE, r, c, 16'($urandom));
   endtask

   // wait for all results, then let a query in flight finish
   task automatic drain();
      int guard;
      @(negedge clock);
      start <= 1'b0;
      guard = 0;
      while (median_queue.size() != 0 && guard < 5000) begin
         @(posedge clock);
         guard++;
      end
      repeat (60) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [mf2d_pkg::CfgBits-1:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == mf2d_pkg::CSR_LINE_WIDTH) width_reg = val;
      else if (idx == mf2d_pkg::CSR_NUM_LINES) lines_reg = val;
      else if (idx == mf2d_pkg::CSR_HALF_WINDOW) half_reg = val[mf2d_pkg::HalfBits-1:0];
   endtask

   task automatic set_frame(int w, int l, int h);
      drain();
      csr_write(mf2d_pkg::CSR_LINE_WIDTH, mf2d_pkg::CfgBits'(w));
      csr_write(mf2d_pkg::CSR_NUM_LINES, mf2d_pkg::CfgBits'(l));
      csr_write(mf2d_pkg::CSR_HALF_WINDOW, mf2d_pkg::CfgBits'(h));
   endtask

   // fill the top-left corner of the frame, at most 12 x 12
   task automatic fill_corner();
      int nr, nc;
      nr = (eff_dim(lines_reg) < 12) ? eff_dim(lines_reg) : 12;
      nc = (eff_dim(width_reg) < 12) ? eff_dim(width_reg) : 12;
      for (int r = 0; r < nr; r++)
         for (int c = 0; c < nc; c++)
            send_op(mf2d_pkg::MODE_WRITE, 8'(r), 8'(c), 16'($urandom));
   endtask

   // corners, edges, saturation outside the frame, passthrough, sample extremes
   task automatic test_directed();
      set_frame(5, 4, 1);
      for (int r = 0; r < 4; r++)
         for (int c = 0; c < 5; c++)
            send_op(mf2d_pkg::MODE_WRITE, 8'(r), 8'(c),
                    (c == 0) ? 16'h0000 : (c == 4) ? 16'hFFFF : 16'($urandom));
      try_query(8'd0, 8'd0);
      try_query(8'd3, 8'd4);
      try_query(8'd255, 8'd255);
      try_query(8'd200, 8'd2);
      set_frame(5, 4, 0);
      try_query(8'd1, 8'd4);
      set_frame(5, 4, 3);
      try_query(8'd2, 8'd2);
      // pause until every outstanding result is back
      drain();
      try_query(8'd0, 8'd255);
   endtask

   task automatic test_random(int w, int l, int h, int count);
      int x, nr, nc;
      set_frame(w, l, h);
      fill_corner();
      nr = (eff_dim(lines_reg) < 12) ? eff_dim(lines_reg) : 12;
      nc = (eff_dim(width_reg) < 12) ? eff_dim(width_reg) : 12;
      for (int i = 0; i < count; i++) begin
         x = $urandom_range(99);
         if (x < 55) try_query(8'($urandom_range(nr + 1)), 8'($urandom_range(nc + 1)));
         else if (x < 65) try_query(8'($urandom), 8'($urandom));
         else if (x < 90)
            send_op(mf2d_pkg::MODE_WRITE, 8'($urandom_range(nr - 1)),
                    8'($urandom_range(nc - 1)), 16'($urandom));
         else send_op(mf2d_pkg::MODE_WRITE, 8'($urandom), 8'($urandom), 16'($urandom));
      end
   endtask

   // result checker
   always @(posedge clock) begin
      filtered_pixel_type e;
      if (!reset && rsp_valid) begin
         if (median_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: median %h row %0d col %0d",
                        rsp_median_value, rsp_out_row, rsp_out_col);
         end else begin
            e = median_queue.pop_front();
            if (rsp_median_value !== e.med || rsp_out_row !== e.row
                || rsp_out_col !== e.col) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %h/%0d/%0d, got %h/%0d/%0d",
                           e.med, e.row, e.col,
                           rsp_median_value, rsp_out_row, rsp_out_col);
            end
         end
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      sender_idle_pct = 25;
      test_directed();
      test_random(8, 8, 3, 125);
      test_random(0, 0, 3, 125);
      test_random(1, 256, 2, 125);
      sender_idle_pct = 46;
      test_random(256, 1, 3, 125);
      test_random(511, 300, 3, 125);
      test_random(16, 12, 0, 125);
      sender_idle_pct = 0;
      test_random(3, 3, 3, 125);
      test_random(256, 256, 1, 125);
      test_random(7, 5, 2, 125);
      drain();
      if (mismatches == 0 && median_queue.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #10000000;
      $display("Simulation FAILED");
      $finish;
   end
endmodule
`default_nettype wire
